@@ hw/rtl/orr_pkg.sv @@
`default_nettype none
package orr_pkg;
  localparam int unsigned DEPTH_DEF        = 64;
  localparam int unsigned PAYLOAD_BITS_DEF = 64;
  localparam int unsigned TS_W             = 32;
  localparam int unsigned SEQ_W            = 32;
  localparam int unsigned CNT_W            = 7;
  localparam int unsigned PL_W             = 64;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_ACK    = 2'd1,
    OP_LATEST = 2'd2,
    OP_BATCH  = 2'd3
  } op_t;

  // one classified command between front and back
  typedef struct packed {
    op_t              op;
    logic [TS_W-1:0]  ts;
    logic [PL_W-1:0]  payload;
    logic [CNT_W-1:0] max_count;
    logic [TS_W-1:0]  after_ts;
  } cmd_t;

  typedef struct packed {
    logic             found;
    logic [SEQ_W-1:0] seq;
    logic [TS_W-1:0]  ts;
    logic [PL_W-1:0]  payload;
    logic             last;
    logic [CNT_W-1:0] count;
    logic [TS_W-1:0]  oldest;
    logic [TS_W-1:0]  acked;
  } res_t;
endpackage
`default_nettype wire

@@ hw/rtl/orr_front.sv @@
`default_nettype none
module orr_front
  import orr_pkg::*;
#(
  parameter int unsigned DEPTH        = DEPTH_DEF,
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [1:0] in_op,
  input  wire logic [TS_W-1:0] in_ts,
  input  wire logic [PAYLOAD_BITS-1:0] in_payload,
  input  wire logic [CNT_W-1:0] in_max_count,
  input  wire logic [TS_W-1:0] in_after_ts,
  output logic            q_valid,
  input  wire logic       q_pop,
  output cmd_t            q_cmd
);
  // two-entry command queue
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       c;
  logic       push;

  always_comb begin
    c           = '0;
    c.op        = op_t'(in_op);
    c.ts        = in_ts;
    c.payload   = PL_W'(in_payload);
    c.max_count = (in_max_count > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : in_max_count;
    c.after_ts  = in_after_ts;
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_cmd     = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop && q_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop && q_valid);
    end
  end

  ast_no_over: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  ast_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !q_valid) else $error("pop from empty");
  ast_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !in_tready) else $error("accept while full");
endmodule
`default_nettype wire

@@ hw/rtl/orr_back.sv @@
`default_nettype none
module orr_back
  import orr_pkg::*;
#(
  parameter int unsigned DEPTH        = DEPTH_DEF,
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [CNT_W-1:0] cfg_wr_data,
  input  wire logic       q_valid,
  output logic            q_pop,
  input  cmd_t            q_cmd,
  output logic            r_valid,
  input  wire logic       r_ready,
  output res_t            r_data
);
  localparam int unsigned AW = $clog2(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_CHK, S_OUT} st_t;

  logic [TS_W-1:0]         ts_mem  [DEPTH];
  logic [SEQ_W-1:0]        seq_mem [DEPTH];
  logic [PAYLOAD_BITS-1:0] pl_mem  [DEPTH];

  st_t              st_r;
  op_t              mode_r;
  logic [CNT_W-1:0] cap_r, cnt_r, left_r, todo_r;
  logic [AW-1:0]    wpos_r, idx_r;
  logic [SEQ_W-1:0] nseq_r;
  logic [TS_W-1:0]  ack_r, oldest_r, after_r;
  logic             have_r, vld_r;
  res_t             res_r;
  logic [TS_W-1:0]  rts_r;
  logic [SEQ_W-1:0] rseq_r;
  logic [PAYLOAD_BITS-1:0] rpl_r;
  logic [AW-1:0]    rd_a;
  logic [CNT_W-1:0] cap_v, push_cnt;
  logic [AW:0]      oi_sum;
  logic [AW-1:0]    idx_inc, wpos_inc, latest_i, push_old_i;
  logic [TS_W-1:0]  ack_nxt;
  logic             hit, chk_final;
  res_t             rec_hit, rec_stat, rec_push;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] v, input logic [CNT_W-1:0] cp);
    logic [AW:0] cz;
    cz = (AW+1)'(cp);
    return (v >= cz) ? AW'(v - cz) : AW'(v);
  endfunction

  always_comb begin
    cap_v = cfg_wr_data;
    if (cap_v < CNT_W'(1)) cap_v = CNT_W'(1);
    if (cap_v > CNT_W'(DEPTH)) cap_v = CNT_W'(DEPTH);
  end

  assign oi_sum     = (AW+1)'(wpos_r) + (AW+1)'(cap_r) - (AW+1)'(cnt_r);
  assign idx_inc    = wrap((AW+1)'(idx_r) + 1'b1, cap_r);
  assign wpos_inc   = wrap((AW+1)'(wpos_r) + 1'b1, cap_r);
  assign latest_i   = wrap((AW+1)'(wpos_r) + (AW+1)'(cap_r) - 1'b1, cap_r);
  assign push_cnt   = (cnt_r < cap_r) ? cnt_r + 1'b1 : cnt_r;
  // a full ring loses its oldest entry, so the oldest moves one up
  assign push_old_i = (cnt_r < cap_r) ? wrap(oi_sum, cap_r) : wpos_inc;
  assign rd_a       = idx_r;

  assign q_pop   = (st_r == S_IDLE) && q_valid && !vld_r && !cfg_wr_en;
  assign r_valid = vld_r;
  assign r_data  = res_r;

  assign ack_nxt   = (q_pop && q_cmd.op == OP_ACK && q_cmd.ts > ack_r) ? q_cmd.ts : ack_r;
  assign hit       = rts_r > after_r;
  assign chk_final = (todo_r == CNT_W'(1)) || (hit && left_r == CNT_W'(1));

  always_comb begin
    rec_stat        = '0;
    rec_stat.last   = 1'b1;
    rec_stat.count  = cnt_r;
    rec_stat.oldest = oldest_r;
    rec_stat.acked  = ack_nxt;

    rec_hit         = rec_stat;
    rec_hit.found   = 1'b1;
    rec_hit.seq     = rseq_r;
    rec_hit.ts      = rts_r;
    rec_hit.payload = PL_W'(rpl_r);
    rec_hit.last    = chk_final;

    rec_push        = '0;
    rec_push.seq    = nseq_r;
    rec_push.last   = 1'b1;
    rec_push.count  = push_cnt;
    rec_push.acked  = ack_r;
  end

  // registered memory read
  always_ff @(posedge clk) begin
    rts_r  <= ts_mem[rd_a];
    rseq_r <= seq_mem[rd_a];
    rpl_r  <= pl_mem[rd_a];
    if (q_pop && q_cmd.op == OP_PUSH) begin
      ts_mem[wpos_r]  <= q_cmd.ts;
      seq_mem[wpos_r] <= nseq_r;
      pl_mem[wpos_r]  <= q_cmd.payload[PAYLOAD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cap_r <= CNT_W'(DEPTH); cnt_r <= '0; wpos_r <= '0;
      nseq_r <= SEQ_W'(1); ack_r <= '0; vld_r <= 1'b0; oldest_r <= '0;
      idx_r <= '0; left_r <= '0; todo_r <= '0; have_r <= 1'b0;
      after_r <= '0; res_r <= '0; mode_r <= OP_PUSH;
    end else if (cfg_wr_en) begin
      cap_r <= cap_v; cnt_r <= '0; wpos_r <= '0; nseq_r <= SEQ_W'(1); ack_r <= '0;
      oldest_r <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: if (q_pop) begin
          mode_r <= q_cmd.op;
          unique case (q_cmd.op)
            OP_PUSH: begin
              res_r  <= rec_push;
              nseq_r <= nseq_r + 1'b1;
              wpos_r <= wpos_inc;
              cnt_r  <= push_cnt;
              idx_r  <= push_old_i;
              st_r   <= S_RD;
            end
            OP_ACK: begin
              ack_r <= ack_nxt;
              res_r <= rec_stat; vld_r <= 1'b1; st_r <= S_OUT;
            end
            OP_LATEST: begin
              if (cnt_r == '0) begin
                res_r <= rec_stat; vld_r <= 1'b1; st_r <= S_OUT;
              end else begin
                idx_r <= latest_i; todo_r <= CNT_W'(1); left_r <= CNT_W'(1);
                st_r <= S_RD;
              end
            end
            default: begin
              if (cnt_r == '0 || q_cmd.max_count == '0) begin
                res_r <= rec_stat; vld_r <= 1'b1; st_r <= S_OUT;
              end else begin
                idx_r <= wrap(oi_sum, cap_r); todo_r <= cnt_r;
                left_r <= q_cmd.max_count; after_r <= q_cmd.after_ts; have_r <= 1'b0;
                st_r <= S_RD;
              end
            end
          endcase
        end
        S_RD: st_r <= S_CHK;
        S_CHK: begin
          unique case (mode_r)
            OP_PUSH: begin
              // read of the new oldest entry completes the push status
              oldest_r <= rts_r; res_r.oldest <= rts_r;
              vld_r <= 1'b1; st_r <= S_OUT;
            end
            OP_LATEST: begin
              res_r <= rec_hit; vld_r <= 1'b1; st_r <= S_OUT;
            end
            default: begin
              // a match is held until the walk shows whether it is the final one
              if (hit && have_r) begin
                have_r <= 1'b0; vld_r <= 1'b1; st_r <= S_OUT;
              end else if (chk_final) begin
                if (hit) res_r <= rec_hit;
                else if (have_r) res_r.last <= 1'b1;
                else res_r <= rec_stat;
                have_r <= 1'b0; vld_r <= 1'b1; st_r <= S_OUT;
              end else begin
                if (hit) begin
                  res_r <= rec_hit; have_r <= 1'b1; left_r <= left_r - 1'b1;
                end
                todo_r <= todo_r - 1'b1; idx_r <= idx_inc; st_r <= S_RD;
              end
            end
          endcase
        end
        S_OUT: if (r_ready) begin
          vld_r <= 1'b0;
          st_r  <= res_r.last ? S_IDLE : S_CHK;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  ast_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= cap_r)
    else $error("count above capacity");
  ast_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cap_r != 0 && cap_r <= CNT_W'(DEPTH)) else $error("capacity out of range");
  ast_ack: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cfg_wr_en) && $past(rst_n) |-> ack_r >= $past(ack_r)) else $error("ack fell");
  ast_vld_out: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> st_r == S_OUT) else $error("result valid outside output state");
endmodule
`default_nettype wire

@@ hw/rtl/overwriting_record_ring_with_ack.sv @@
`default_nettype none
// Ring of timestamped records that overwrites the oldest entry when full,
// with auto sequence numbers and a monotonic ack timestamp. A front queue
// takes commands; the back engine runs them against the record memory.
// Push and read-latest run a registered memory read, a compare and the
// result transfer before the next command leaves the queue; ack, reads of
// an empty store and batch reads with a zero max_count go straight to the
// result transfer. A batch read reads and compares each entry it walks and
// sends each record returned; output stalls hold the result transfer.
// Writing cfg_wr_data clears the store and the ack.
module overwriting_record_ring_with_ack
  import orr_pkg::*;
#(
  parameter int unsigned DEPTH        = DEPTH_DEF,
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic [6:0]   cfg_wr_data,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // opcode[1:0], in_ts[33:2], in_payload[97:34], max_count[104:98],
  // after_ts[136:105], zero fill
  input  wire logic [143:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic              out_tlast,
  // found[0], rec_seq[32:1], rec_ts[64:33], rec_payload[128:65],
  // stored_count[135:129], oldest_ts[167:136], acked_ts[199:168]
  output logic [199:0]      out_tdata
);
  logic q_valid, q_pop, r_valid;
  cmd_t q_cmd;
  res_t r;

  orr_front #(.DEPTH(DEPTH), .PAYLOAD_BITS(PAYLOAD_BITS)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_op(in_tdata[1:0]), .in_ts(in_tdata[33:2]),
    .in_payload(in_tdata[34 +: PAYLOAD_BITS]),
    .in_max_count(in_tdata[104:98]), .in_after_ts(in_tdata[136:105]),
    .q_valid, .q_pop, .q_cmd
  );

  orr_back #(.DEPTH(DEPTH), .PAYLOAD_BITS(PAYLOAD_BITS)) u_back (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data, .q_valid, .q_pop, .q_cmd,
    .r_valid, .r_ready(out_tready), .r_data(r)
  );

  assign out_tvalid = r_valid;
  assign out_tlast  = r.last;
  assign out_tdata  = {r.acked, r.oldest, r.count, r.payload, r.ts, r.seq, r.found};
endmodule
`default_nettype wire
